// ===== hw/rtl/progress_deadline_watchdog_macros.svh =====
// Assertion macros for the progress deadline watchdog checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef PROGRESS_DEADLINE_WATCHDOG_MACROS_SVH
`define PROGRESS_DEADLINE_WATCHDOG_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define PDW_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define PDW_ASSERT(lbl, prop, msg) \
  `PDW_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/pdw_pkg.sv =====
// Shared types, codes and constants of the progress deadline watchdog.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdw_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int PAGE_ITEMS_DEF = 128;

  localparam int CNT_W   = 24;           // secret / check counts
  localparam int MS_W    = 32;
  localparam int RATE_W  = 16;           // per-call and per-op allowances
  localparam int CALLS_W = 27;           // estimated db calls / crypto ops
  localparam int PROD_W  = CALLS_W + RATE_W;
  localparam int ALLOW_W = PROD_W + 1;   // fixed + two products
  localparam int OUT_DL_W = 49;

  localparam int DB_BASE = 64;

  // action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_PROG    = 3'd2;
  localparam logic [2:0] ACT_QUERY   = 3'd3;
  localparam logic [2:0] ACT_CLEANUP = 3'd4;

  // register indexes
  localparam logic [2:0] REG_STALL   = 3'd0;
  localparam logic [2:0] REG_CLEANUP = 3'd1;
  localparam logic [2:0] REG_FIXED   = 3'd2;
  localparam logic [2:0] REG_DB      = 3'd3;
  localparam logic [2:0] REG_CRYPTO  = 3'd4;
  localparam logic [2:0] REG_SECRET  = 3'd5;
  localparam logic [2:0] REG_CHECK   = 3'd6;
  localparam logic [2:0] REG_INV     = 3'd7;

  typedef struct packed {
    logic [MS_W-1:0]   stall_ms;
    logic [MS_W-1:0]   cleanup_ms;
    logic [MS_W-1:0]   fixed_ms;
    logic [RATE_W-1:0] db_call_ms;
    logic [RATE_W-1:0] crypto_op_ms;
    logic [CNT_W-1:0]  secret_total;
    logic [CNT_W-1:0]  check_total;
    logic              inventory_enable;
  } cfg_t;

  typedef struct packed {
    logic [OUT_DL_W-1:0] deadline_ms;
    logic                expired;
    logic                refused;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/progress_deadline_watchdog.sv =====
// Progress deadline watchdog: each accepted item's result is written to the result register;
// one item per cycle while the allowance is valid and the output is not stalled; the output
// register lets a new item in while the previous result is taken in the same cycle.
// After reset and after each config write the hard allowance is recomputed step by step
// (page counts, call/op estimates, products, sum); s_tready_o stays low meanwhile.
// Reset is asynchronous, active low; config registers take their documented defaults.
`timescale 1ns / 1ps
`default_nettype none

module progress_deadline_watchdog #(
  parameter int TIME_BITS  = pdw_pkg::TIME_BITS_DEF,
  parameter int PAGE_ITEMS = pdw_pkg::PAGE_ITEMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [79:0] s_tdata_i,   // phase[15:0], position[47:16], call_ms[79:48]
  input  wire logic [2:0]  s_tuser_i,   // action[2:0]
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [55:0]      m_tdata_o,   // refused[0], expired[1], deadline_ms[50:2], zero pad
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  pdw_pkg::cfg_t    cfg_q;
  pdw_pkg::result_t res, res_q;
  logic             out_valid_q;
  logic             cfg_we, take, allow_valid;
  logic [pdw_pkg::ALLOW_W-1:0] allow;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign s_tready_o  = allow_valid && (!out_valid_q || m_tready_i);
  assign take        = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_ms         <= 32'd30000;
      cfg_q.cleanup_ms       <= 32'd5000;
      cfg_q.fixed_ms         <= 32'd10000;
      cfg_q.db_call_ms       <= 16'd10;
      cfg_q.crypto_op_ms     <= 16'd5;
      cfg_q.secret_total     <= '0;
      cfg_q.check_total      <= '0;
      cfg_q.inventory_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        pdw_pkg::REG_STALL:   cfg_q.stall_ms         <= cfg_data_i;
        pdw_pkg::REG_CLEANUP: cfg_q.cleanup_ms       <= cfg_data_i;
        pdw_pkg::REG_FIXED:   cfg_q.fixed_ms         <= cfg_data_i;
        pdw_pkg::REG_DB:      cfg_q.db_call_ms       <= cfg_data_i[15:0];
        pdw_pkg::REG_CRYPTO:  cfg_q.crypto_op_ms     <= cfg_data_i[15:0];
        pdw_pkg::REG_SECRET:  cfg_q.secret_total     <= cfg_data_i[23:0];
        pdw_pkg::REG_CHECK:   cfg_q.check_total      <= cfg_data_i[23:0];
        pdw_pkg::REG_INV:     cfg_q.inventory_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pdw_allow #(.PAGE_ITEMS(PAGE_ITEMS)) u_allow (
    .clk_i, .rst_ni, .restart_i(cfg_we), .cfg_i(cfg_q),
    .valid_o(allow_valid), .allow_o(allow)
  );

  pdw_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk_i,
    .rst_ni,
    .take_i       (take),
    .action_i     (s_tuser_i),
    .phase_i      (s_tdata_i[15:0]),
    .position_i   (s_tdata_i[47:16]),
    .call_ms_i    (s_tdata_i[79:48]),
    .cfg_i        (cfg_q),
    .allow_i      (allow),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {5'b0, res_q};

endmodule

`default_nettype wire

// ===== hw/rtl/pdw_page_div.sv =====
// Page count by reciprocal multiplication: registered floor(n / DIVISOR).
// Used for page counts of the hard allowance; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pdw_page_div #(
  parameter int DIVISOR = 128,
  parameter int W       = 25
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] n_i,
  output logic [W-1:0]      q_o
);

  // floor(n / d) = (n * M) >> K with M = ceil(2^K / d), exact for every W-bit n
  localparam int     LW = $clog2(DIVISOR);
  localparam int     K  = W + LW;
  localparam int     PW = K + W;
  localparam longint M  = ((longint'(1) << K) + longint'(DIVISOR) - longint'(1))
                          / longint'(DIVISOR);

  logic [PW-1:0] prod;
  logic [W-1:0]  quo_q;

  assign prod = PW'(n_i) * PW'(M);

  always_ff @(posedge clk_i) begin
    quo_q <= prod[K +: W];
  end

  assign q_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pdw_allow.sv =====
// Hard allowance precompute: page counts, call/op estimates, products, sum.
// Depends on pdw_pkg and pdw_page_div. Restarts on every config write.
`timescale 1ns / 1ps
`default_nettype none

module pdw_allow #(
  parameter int PAGE_ITEMS = pdw_pkg::PAGE_ITEMS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        restart_i,
  input  wire pdw_pkg::cfg_t               cfg_i,
  output logic                             valid_o,
  output logic [pdw_pkg::ALLOW_W-1:0]      allow_o
);

  localparam int NW = pdw_pkg::CNT_W + 1;
  localparam int CW = pdw_pkg::CALLS_W;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_IDLE = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [NW-1:0] s_round, c_round, s_pages, c_pages;
  logic [CW-1:0] s_ext, c_ext, sp_ext, cp_ext;
  logic [CW-1:0] calls_q, ops_q;
  logic [pdw_pkg::PROD_W-1:0]  db_prod_q, op_prod_q;
  logic [pdw_pkg::ALLOW_W-1:0] allow_q;

  assign s_round = {1'b0, cfg_i.secret_total} + NW'(PAGE_ITEMS - 1);
  assign c_round = {1'b0, cfg_i.check_total} + NW'(PAGE_ITEMS - 1);

  // page counts are registered: valid from the cycle after ST_LOAD
  pdw_page_div #(.DIVISOR(PAGE_ITEMS), .W(NW)) u_sdiv (
    .clk_i, .n_i(s_round), .q_o(s_pages)
  );
  pdw_page_div #(.DIVISOR(PAGE_ITEMS), .W(NW)) u_cdiv (
    .clk_i, .n_i(c_round), .q_o(c_pages)
  );

  assign s_ext  = {{(CW - pdw_pkg::CNT_W){1'b0}}, cfg_i.secret_total};
  assign c_ext  = {{(CW - pdw_pkg::CNT_W){1'b0}}, cfg_i.check_total};
  assign sp_ext = {{(CW - NW){1'b0}}, s_pages};
  assign cp_ext = {{(CW - NW){1'b0}}, c_pages};

  always_comb begin
    st_d = st_q;
    if (restart_i) begin
      st_d = ST_LOAD;
    end else begin
      case (st_q)
        ST_LOAD: st_d = ST_DIV;
        ST_DIV:  st_d = ST_MUL;
        ST_MUL:  st_d = ST_ADD;
        ST_ADD:  st_d = ST_IDLE;
        ST_IDLE: st_d = ST_IDLE;
        default: st_d = ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DIV) begin
      calls_q <= CW'(pdw_pkg::DB_BASE) + s_ext + c_ext + (sp_ext << 1)
                 + (cp_ext << 1) + cp_ext;
      ops_q   <= (s_ext << 1) + s_ext + (c_ext << 2);
    end
    if (st_q == ST_MUL) begin
      db_prod_q <= calls_q * cfg_i.db_call_ms;
      op_prod_q <= ops_q * cfg_i.crypto_op_ms;
    end
    if (st_q == ST_ADD) begin
      allow_q <= {{(pdw_pkg::ALLOW_W - pdw_pkg::MS_W){1'b0}}, cfg_i.fixed_ms}
                 + {1'b0, db_prod_q} + {1'b0, op_prod_q};
    end
  end

  assign valid_o = (st_q == ST_IDLE);
  assign allow_o = allow_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pdw_core.sv =====
// Watchdog state and per-item decision logic, one item per cycle while take_i is high.
// Depends on pdw_pkg; the hard allowance comes precomputed from pdw_allow.
`timescale 1ns / 1ps
`default_nettype none

module pdw_core #(
  parameter int TIME_BITS = pdw_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        take_i,
  input  wire logic [2:0]                  action_i,
  input  wire logic [15:0]                 phase_i,
  input  wire logic [31:0]                 position_i,
  input  wire logic [31:0]                 call_ms_i,
  input  wire pdw_pkg::cfg_t               cfg_i,
  input  wire logic [pdw_pkg::ALLOW_W-1:0] allow_i,
  output pdw_pkg::result_t                 res_o
);

  localparam int DW = ((TIME_BITS > pdw_pkg::ALLOW_W) ? TIME_BITS : pdw_pkg::ALLOW_W) + 1;

  logic [TIME_BITS-1:0] elapsed_q, elapsed_d;
  logic armed_q, armed_d, hard_q, hard_d, seen_q, seen_d, cl_on_q, cl_on_d;
  logic [DW-1:0] sdl_q, sdl_d, hdl_q, hdl_d, cdl_q, cdl_d;
  logic [15:0] lph_q, lph_d;
  logic [31:0] lpos_q, lpos_d;

  logic [DW-1:0] now, now_next, now_stall, now_hard, now_cl, now_pc, granted, prog_dl;
  logic exp_before, exp_after, stale, refused;

  function automatic logic is_exp(input logic armed, input logic cl_on, input logic hard,
                                  input logic [DW-1:0] t, input logic [DW-1:0] sdl,
                                  input logic [DW-1:0] hdl, input logic [DW-1:0] cdl);
    logic r;
    if (!armed) r = 1'b0;
    else if (cl_on) r = t >= cdl;
    else r = (t >= sdl) || (hard && t >= hdl);
    return r;
  endfunction

  assign now       = {{(DW - TIME_BITS){1'b0}}, elapsed_q};
  assign now_next  = {{(DW - TIME_BITS){1'b0}}, elapsed_d};
  assign now_stall = now + {{(DW - 32){1'b0}}, cfg_i.stall_ms};
  assign now_cl    = now + {{(DW - 32){1'b0}}, cfg_i.cleanup_ms};
  assign now_pc    = now + {{(DW - 32){1'b0}}, call_ms_i};
  assign now_hard  = now + {{(DW - pdw_pkg::ALLOW_W){1'b0}}, allow_i};
  assign prog_dl   = (hard_q && now_stall > hdl_q) ? hdl_q : now_stall;

  assign exp_before = is_exp(armed_q, cl_on_q, hard_q, now, sdl_q, hdl_q, cdl_q);
  assign stale = seen_q && ((phase_i < lph_q) || (phase_i == lph_q && position_i <= lpos_q));

  always_comb begin
    elapsed_d = elapsed_q;
    armed_d = armed_q;
    hard_d  = hard_q;
    seen_d  = seen_q;
    cl_on_d = cl_on_q;
    sdl_d   = sdl_q;
    hdl_d   = hdl_q;
    cdl_d   = cdl_q;
    lph_d   = lph_q;
    lpos_d  = lpos_q;
    refused = 1'b0;
    granted = '0;
    if (take_i) begin
      case (action_i)
        pdw_pkg::ACT_TICK: begin
          if (elapsed_q != '1) elapsed_d = elapsed_q + 1'b1;
        end
        pdw_pkg::ACT_START: begin
          armed_d = 1'b1;
          seen_d  = 1'b0;
          lph_d   = '0;
          lpos_d  = '0;
          cl_on_d = 1'b0;
          cdl_d   = '0;
          sdl_d   = now_stall;
          hard_d  = cfg_i.inventory_enable;
          hdl_d   = cfg_i.inventory_enable ? now_hard : '0;
          // now >= now + x only when x is zero
          refused = cfg_i.inventory_enable && (cfg_i.stall_ms == '0 || allow_i == '0);
        end
        pdw_pkg::ACT_PROG: begin
          if (!armed_q || exp_before || stale) begin
            refused = 1'b1;
          end else begin
            sdl_d  = prog_dl;
            lph_d  = phase_i;
            lpos_d = position_i;
            seen_d = 1'b1;
          end
        end
        pdw_pkg::ACT_QUERY: begin
          if (!armed_q || call_ms_i == '0 || exp_before) begin
            refused = 1'b1;
          end else begin
            granted = now_pc;
            if (cl_on_q) begin
              if (granted > cdl_q) granted = cdl_q;
            end else begin
              if (granted > sdl_q) granted = sdl_q;
              if (hard_q && granted > hdl_q) granted = hdl_q;
            end
          end
        end
        pdw_pkg::ACT_CLEANUP: begin
          if (!armed_q) begin
            refused = 1'b1;
          end else if (!cl_on_q) begin
            cdl_d   = now_cl;
            cl_on_d = 1'b1;
            refused = cfg_i.cleanup_ms == '0;
          end else begin
            refused = now >= cdl_q;
          end
        end
        default: refused = 1'b1;
      endcase
    end
  end

  assign exp_after = is_exp(armed_d, cl_on_d, hard_d, now_next, sdl_d, hdl_d, cdl_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      armed_q   <= 1'b0;
      hard_q    <= 1'b0;
      seen_q    <= 1'b0;
      cl_on_q   <= 1'b0;
      sdl_q     <= '0;
      hdl_q     <= '0;
      cdl_q     <= '0;
      lph_q     <= '0;
      lpos_q    <= '0;
    end else begin
      elapsed_q <= elapsed_d;
      armed_q   <= armed_d;
      hard_q    <= hard_d;
      seen_q    <= seen_d;
      cl_on_q   <= cl_on_d;
      sdl_q     <= sdl_d;
      hdl_q     <= hdl_d;
      cdl_q     <= cdl_d;
      lph_q     <= lph_d;
      lpos_q    <= lpos_d;
    end
  end

  assign res_o.refused = refused;
  assign res_o.expired = exp_after;

  generate
    if (DW >= pdw_pkg::OUT_DL_W) begin : g_trunc
      assign res_o.deadline_ms = granted[pdw_pkg::OUT_DL_W-1:0];
    end else begin : g_ext
      assign res_o.deadline_ms = {{(pdw_pkg::OUT_DL_W - DW){1'b0}}, granted};
    end
  endgenerate

endmodule

`default_nettype wire

// ===== hw/rtl/pdw_checker.sv =====
// Port-level checker for the progress deadline watchdog, bound to the top level.
// Depends on progress_deadline_watchdog_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "progress_deadline_watchdog_macros.svh"

module pdw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [55:0] m_tdata_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o
);

  `PDW_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "result dropped or changed while stalled")
  `PDW_ASSERT(a_item_gives_result, s_tvalid_i && s_tready_o |=> m_tvalid_o, "accepted item produced no result")
  `PDW_ASSERT(a_no_take_when_full, m_tvalid_o && !m_tready_i |-> !s_tready_o, "input ready while result register is stalled")
  `PDW_ASSERT(a_cfg_recompute, cfg_valid_i && cfg_ready_o |=> !s_tready_o, "input ready right after a config write")

endmodule

bind progress_deadline_watchdog pdw_checker u_pdw_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for progress_deadline_watchdog: directed table, then random phases.
// Verdicts are predicted in-bench or taken from typed table rows, and checked per result item.
// Depends on pdw_pkg and the progress_deadline_watchdog RTL only.
`timescale 1ns / 1ps

module testbench;

  import pdw_pkg::*;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int DRAIN_CYCLES  = 6;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 144;
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS_DEF) - 64'd1;

  // reserved action codes, always refused
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  // config presets used by the directed table
  localparam logic [1:0] CFG_KEEP      = 2'd0;
  localparam logic [1:0] CFG_TIGHT     = 2'd1;
  localparam logic [1:0] CFG_NO_BUDGET = 2'd2;
  localparam logic [1:0] CFG_MAX       = 2'd3;

  localparam cfg_t CFG_RESET = '{32'd30000, 32'd5000, 32'd10000, 16'd10, 16'd5,
                                 24'd0, 24'd0, 1'b0};

  localparam cfg_t CFG_PRESETS [4] = '{
    CFG_RESET,
    '{32'd3, 32'd0, 32'd2, 16'd0, 16'd0, 24'd0, 24'd0, 1'b1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 16'd0, 16'd0, 24'd0, 24'd0, 1'b1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
      24'hFF_FFFF, 24'hFF_FFFF, 1'b1}
  };

  typedef struct packed {
    logic [1:0]  cfg_sel;
    logic [2:0]  act;
    logic [15:0] phase;
    logic [31:0] pos;
    logic [31:0] per_call;
    logic        typed;
    logic        refused;
    logic        expired;
    logic [48:0] deadline;
  } stim_row_t;

  localparam int NUM_DIR = 26;

  // typed = 0: verdict comes from the predictor
  localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'd5,         1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_PROG,    16'h1,    32'h1,         32'h0,         1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_CLEANUP, 16'h0,    32'h0,         32'h0,         1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_RSVD7,   16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_TICK,    16'h0,    32'h0,         32'h0,         1'b1, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_START,   16'h0,    32'h0,         32'h0,         1'b1, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'h0,         1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
      49'd30001},
    '{CFG_KEEP,      ACT_PROG,    16'h0,    32'h0,         32'h0,         1'b1, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_PROG,    16'h0,    32'h0,         32'h0,         1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_PROG,    16'hFFFF, 32'h0,         32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_PROG,    16'hFFFE, 32'hFFFF_FFFF, 32'h0,         1'b1, 1'b1, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_PROG,    16'hFFFF, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_CLEANUP, 16'h0,    32'h0,         32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_CLEANUP, 16'h0,    32'h0,         32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0,
      49'd5001},
    '{CFG_TIGHT,     ACT_START,   16'h0,    32'h0,         32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'd100,       1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_TICK,    16'h0,    32'h0,         32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_TICK,    16'h0,    32'h0,         32'h0,         1'b1, 1'b0, 1'b1, 49'd0},
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'd1,         1'b1, 1'b1, 1'b1, 49'd0},
    '{CFG_KEEP,      ACT_PROG,    16'h5,    32'h5,         32'h0,         1'b1, 1'b1, 1'b1, 49'd0},
    '{CFG_KEEP,      ACT_CLEANUP, 16'h0,    32'h0,         32'h0,         1'b1, 1'b1, 1'b1, 49'd0},
    '{CFG_NO_BUDGET, ACT_START,   16'h0,    32'h0,         32'h0,         1'b1, 1'b1, 1'b1, 49'd0},
    '{CFG_MAX,       ACT_START,   16'h0,    32'h0,         32'h0,         1'b0, 1'b0, 1'b0, 49'd0},
    '{CFG_KEEP,      ACT_QUERY,   16'h0,    32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 49'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [79:0] s_tdata_i;   // phase[15:0], position[47:16], call_ms[79:48]
  logic [2:0]  s_tuser_i;   // action[2:0]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [55:0] m_tdata_o;   // refused[0], expired[1], deadline_ms[50:2], zero pad
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // watchdog shadow state
  cfg_t        wd_cfg;
  logic [63:0] elapsed;
  logic [63:0] stall_dl, hard_dl, cleanup_dl;
  logic        armed, hard_armed, prog_seen, cleanup_on;
  logic [15:0] last_ph;
  logic [31:0] last_pos;

  result_t     verdict_q [$];
  int          mismatches;
  int          send_pct;
  int          recv_pct;

  progress_deadline_watchdog dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  function automatic logic [63:0] pages_of(input logic [63:0] n);
    return n / PAGE_ITEMS_DEF + ((n % PAGE_ITEMS_DEF) != 0 ? 64'd1 : 64'd0);
  endfunction

  function automatic bit deadline_hit();
    if (!armed) return 1'b0;
    if (cleanup_on) return elapsed >= cleanup_dl;
    return (elapsed >= stall_dl) || (hard_armed && elapsed >= hard_dl);
  endfunction

  task automatic reset_watchdog_state();
    wd_cfg     = CFG_RESET;
    elapsed    = '0;
    stall_dl   = '0;
    hard_dl    = '0;
    cleanup_dl = '0;
    armed      = 1'b0;
    hard_armed = 1'b0;
    prog_seen  = 1'b0;
    cleanup_on = 1'b0;
    last_ph    = '0;
    last_pos   = '0;
  endtask

  task automatic predict_verdict(input logic [2:0] act, input logic [15:0] ph,
                                 input logic [31:0] pos, input logic [31:0] per_call,
                                 output result_t v);
    logic [63:0] now, dl, call_est, op_est, s, c;
    now = elapsed;
    v   = '0;
    dl  = '0;
    s   = 64'(wd_cfg.secret_total);
    c   = 64'(wd_cfg.check_total);
    case (act)
      ACT_TICK: begin
        if (elapsed < TIME_MAX) elapsed = elapsed + 64'd1;
      end
      ACT_START: begin
        armed      = 1'b1;
        prog_seen  = 1'b0;
        last_ph    = '0;
        last_pos   = '0;
        cleanup_on = 1'b0;
        cleanup_dl = '0;
        stall_dl   = now + 64'(wd_cfg.stall_ms);
        hard_armed = 1'b0;
        hard_dl    = '0;
        if (wd_cfg.inventory_enable) begin
          call_est   = DB_BASE + s + c + 2 * pages_of(s) + 3 * pages_of(c);
          op_est     = 3 * s + 4 * c;
          hard_dl    = now + 64'(wd_cfg.fixed_ms) + call_est * 64'(wd_cfg.db_call_ms)
                       + op_est * 64'(wd_cfg.crypto_op_ms);
          hard_armed = 1'b1;
          v.refused  = deadline_hit();
        end
      end
      ACT_PROG: begin
        if (!armed || deadline_hit() ||
            (prog_seen && (ph < last_ph || (ph == last_ph && pos <= last_pos)))) begin
          v.refused = 1'b1;
        end else begin
          dl = now + 64'(wd_cfg.stall_ms);
          if (hard_armed && dl > hard_dl) dl = hard_dl;
          last_ph   = ph;
          last_pos  = pos;
          prog_seen = 1'b1;
          stall_dl  = dl;
        end
      end
      ACT_QUERY: begin
        if (!armed || per_call == '0 || deadline_hit()) begin
          v.refused = 1'b1;
        end else begin
          dl = now + 64'(per_call);
          if (cleanup_on) begin
            if (dl > cleanup_dl) dl = cleanup_dl;
          end else begin
            if (dl > stall_dl) dl = stall_dl;
            if (hard_armed && dl > hard_dl) dl = hard_dl;
          end
          v.deadline_ms = dl[OUT_DL_W-1:0];
        end
      end
      ACT_CLEANUP: begin
        if (!armed) begin
          v.refused = 1'b1;
        end else begin
          // the grace window opens once; repeats only re-check it
          if (!cleanup_on) begin
            cleanup_dl = now + 64'(wd_cfg.cleanup_ms);
            cleanup_on = 1'b1;
          end
          v.refused = now >= cleanup_dl;
        end
      end
      default: v.refused = 1'b1;
    endcase
    v.expired = deadline_hit();
  endtask

  task automatic push_item(input logic [2:0] act, input logic [15:0] ph,
                           input logic [31:0] pos, input logic [31:0] per_call,
                           input bit typed, input result_t typed_v);
    result_t v;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= act;
    s_tdata_i  <= {per_call, pos, ph};
    do @(posedge clk_i); while (s_tready_o !== 1'b1);
    predict_verdict(act, ph, pos, per_call, v);
    if (typed) v = typed_v;
    verdict_q.push_back(v);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(REG_STALL,   c.stall_ms);
    write_reg(REG_CLEANUP, c.cleanup_ms);
    write_reg(REG_FIXED,   c.fixed_ms);
    write_reg(REG_DB,      32'(c.db_call_ms));
    write_reg(REG_CRYPTO,  32'(c.crypto_op_ms));
    write_reg(REG_SECRET,  32'(c.secret_total));
    write_reg(REG_CHECK,   32'(c.check_total));
    write_reg(REG_INV,     32'(c.inventory_enable));
    cfg_valid_i <= 1'b0;
    wd_cfg = c;
  endtask

  // wait until every result item is back, then add slack
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] random_count();
    if ($urandom_range(2) == 0) return 24'(128 * $urandom_range(0, 2));
    return 24'($urandom_range(0, 300));
  endfunction

  function automatic cfg_t random_cfg(input bit wide);
    cfg_t c;
    if (wide) begin
      c.stall_ms     = $urandom;
      c.cleanup_ms   = $urandom;
      c.fixed_ms     = $urandom;
      c.db_call_ms   = 16'($urandom);
      c.crypto_op_ms = 16'($urandom);
      c.secret_total = 24'($urandom);
      c.check_total  = 24'($urandom);
    end else begin
      // short windows so that expiry happens within a few ticks
      c.stall_ms     = $urandom_range(0, 24);
      c.cleanup_ms   = $urandom_range(0, 16);
      c.fixed_ms     = $urandom_range(0, 40);
      c.db_call_ms   = 16'($urandom_range(0, 1) ? 0 : $urandom_range(0, 2));
      c.crypto_op_ms = 16'($urandom_range(0, 2));
      c.secret_total = random_count();
      c.check_total  = random_count();
    end
    c.inventory_enable = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic make_random_item(output logic [2:0] act, output logic [15:0] ph,
                                  output logic [31:0] pos, output logic [31:0] pc);
    int r;
    ph  = 16'($urandom);
    pos = $urandom;
    pc  = $urandom;
    r   = $urandom_range(99);
    if (!armed && r < 40) begin
      act = ACT_START;
    end else begin
      r = $urandom_range(99);
      if (r < 40)      act = ACT_TICK;
      else if (r < 45) act = ACT_START;
      else if (r < 70) act = ACT_PROG;
      else if (r < 90) act = ACT_QUERY;
      else if (r < 96) act = ACT_CLEANUP;
      else             act = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
    end
    // mostly in-order progress; the rest is arbitrary
    if (act == ACT_PROG && prog_seen && $urandom_range(99) < 80) begin
      if ($urandom_range(0, 1)) begin
        ph  = last_ph;
        pos = last_pos + 32'($urandom_range(1, 4));
      end else begin
        ph = last_ph + 16'd1;
      end
    end
    if (act == ACT_QUERY) begin
      r = $urandom_range(9);
      if (r == 0)     pc = '0;
      else if (r < 7) pc = $urandom_range(1, 40);
    end
  endtask

  task automatic check_verdict(input result_t got);
    result_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: result with nothing expected: refused %0d expired %0d deadline %0d",
               $time, got.refused, got.expired, got.deadline_ms);
      mismatches++;
    end else begin
      want = verdict_q.pop_front();
      if (got.refused !== want.refused) begin
        $display("%0t: refused expected %0d actual %0d", $time, want.refused, got.refused);
        mismatches++;
      end
      if (got.expired !== want.expired) begin
        $display("%0t: expired expected %0d actual %0d", $time, want.expired, got.expired);
        mismatches++;
      end
      if (got.deadline_ms !== want.deadline_ms) begin
        $display("%0t: deadline_ms expected %0d actual %0d", $time,
                 want.deadline_ms, got.deadline_ms);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_tvalid_o === 1'b1 && m_tready_i === 1'b1) begin
      check_verdict(result_t'(m_tdata_o[OUT_DL_W+1:0]));
    end
    m_tready_i <= (recv_pct != 0) ? ($urandom_range(99) >= recv_pct) : 1'b1;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

  initial begin
    result_t     tv;
    logic [2:0]  act;
    logic [15:0] ph;
    logic [31:0] pos, pc;
    rst_ni      <= 1'b0;
    s_tvalid_i  <= 1'b0;
    s_tuser_i   <= '0;
    s_tdata_i   <= '0;
    m_tready_i  <= 1'b1;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    send_pct   = 0;
    recv_pct   = 0;
    mismatches = 0;
    reset_watchdog_state();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < NUM_DIR; n++) begin
      if (DIR_ROWS[n].cfg_sel != CFG_KEEP) begin
        drain();
        write_config(CFG_PRESETS[DIR_ROWS[n].cfg_sel]);
      end
      tv.refused     = DIR_ROWS[n].refused;
      tv.expired     = DIR_ROWS[n].expired;
      tv.deadline_ms = DIR_ROWS[n].deadline;
      push_item(DIR_ROWS[n].act, DIR_ROWS[n].phase, DIR_ROWS[n].pos, DIR_ROWS[n].per_call,
                DIR_ROWS[n].typed, tv);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_config(random_cfg(p % 3 == 2));
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 79; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 79; end
        default: begin send_pct = 29; recv_pct = 29; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        make_random_item(act, ph, pos, pc);
        push_item(act, ph, pos, pc, 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
